[rtl/ucal_pkg.sv]
// shared constants and helper functions for the unix seconds to calendar converter
package ucal_pkg;

  // register stages from input to output register
  localparam int STAGES = 7;

  localparam logic [31:0] EPOCH_2000 = 32'd946684800;
  localparam logic [31:0] LAST_2099  = 32'd4102444799;

  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

  // reciprocal multipliers, exact for the stated dividend widths
  // day number: (rest >> 7) / 675, 25-bit dividend
  localparam int          DAY_K = 35;
  localparam logic [25:0] DAY_M = 26'(((64'd1 << DAY_K) + 64'd674) / 64'd675);
  // four-year cycle: day / 1461, 16-bit dividend
  localparam int          CYC_K = 27;
  localparam logic [16:0] CYC_M = 17'(((64'd1 << CYC_K) + 64'd1460) / 64'd1461);
  // hour: (sod >> 4) / 225, 13-bit dividend
  localparam int          HOUR_K = 21;
  localparam logic [13:0] HOUR_M = 14'(((64'd1 << HOUR_K) + 64'd224) / 64'd225);
  // minute: (rem >> 2) / 15, 10-bit dividend
  localparam int          MIN_K = 14;
  localparam logic [10:0] MIN_M = 11'(((64'd1 << MIN_K) + 64'd14) / 64'd15);

  typedef logic [8:0] doy_t;

  // first day of each year within a four-year cycle, leap year first
  function automatic logic [10:0] year_start(input logic [1:0] yic);
    logic [10:0] s;
    case (yic)
      2'd0:    s = 11'd0;
      2'd1:    s = 11'd366;
      2'd2:    s = 11'd731;
      2'd3:    s = 11'd1096;
      default: s = 11'd0;
    endcase
    return s;
  endfunction

  // first day of each month within the year, from the month length table
  function automatic doy_t month_start(input logic [3:0] idx, input logic leap);
    doy_t s;
    case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

[rtl/ucal_if.sv]
// valid/ready channel interfaces for timestamps in and calendar results out
interface ucal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

interface ucal_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] year_offset;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic       out_of_range;

  modport source (output valid, output year_offset, output month, output day, output hour,
                  output minute, output second, output out_of_range, input ready);
  modport sink (input valid, input year_offset, input month, input day, input hour,
                input minute, input second, input out_of_range, output ready);
endinterface

[rtl/ucal_daysplit.sv]
// stages 2 and 3: split seconds since 2000 into day number and second of day
module ucal_daysplit import ucal_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] rest,
  output logic [15:0] day_num,
  output logic [16:0] sod
);

  logic [15:0] day_r, day_nxt;
  logic [31:0] rest2_r;
  logic [16:0] sod_r, sod_nxt;
  logic [50:0] day_prod;
  logic [32:0] back_prod;

  always_comb begin
    day_prod = 51'(rest[31:7]) * 51'(DAY_M);
    day_nxt  = day_prod[DAY_K+15:DAY_K];
  end

  always_comb begin
    back_prod = 33'(day_r) * 33'(SECS_PER_DAY);
    sod_nxt   = 17'(rest2_r - back_prod[31:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_r   <= day_nxt;
      rest2_r <= rest;
      sod_r   <= sod_nxt;
    end
  end

  assign day_num = day_r;
  assign sod     = sod_r;

endmodule

[rtl/ucal_tod.sv]
// stages 4 to 7: hour, minute and second from the second of day
module ucal_tod import ucal_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] sod,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [4:0]  hour4_r, hour4_nxt, hour5_r, hour6_r, hour7_r;
  logic [16:0] sod4_r;
  logic [11:0] remh5_r, remh5_nxt, remh6_r;
  logic [5:0]  min6_r, min6_nxt, min7_r;
  logic [5:0]  sec7_r, sec7_nxt;
  logic [26:0] hour_prod;
  logic [16:0] hour_back;
  logic [20:0] min_prod;
  logic [11:0] min_back;

  always_comb begin
    hour_prod = 27'(sod[16:4]) * 27'(HOUR_M);
    hour4_nxt = hour_prod[HOUR_K+4:HOUR_K];
  end

  always_comb begin
    hour_back = 17'(hour4_r) * 17'(SECS_PER_HOUR);
    remh5_nxt = 12'(sod4_r - hour_back);
  end

  always_comb begin
    min_prod = 21'(remh5_r[11:2]) * 21'(MIN_M);
    min6_nxt = min_prod[MIN_K+5:MIN_K];
  end

  always_comb begin
    min_back = 12'(min6_r) * 12'(SECS_PER_MIN);
    sec7_nxt = 6'(remh6_r - min_back);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hour4_r <= hour4_nxt;
      sod4_r  <= sod;
      hour5_r <= hour4_r;
      remh5_r <= remh5_nxt;
      hour6_r <= hour5_r;
      remh6_r <= remh5_r;
      min6_r  <= min6_nxt;
      hour7_r <= hour6_r;
      min7_r  <= min6_r;
      sec7_r  <= sec7_nxt;
    end
  end

  assign hour   = hour7_r;
  assign minute = min7_r;
  assign second = sec7_r;

endmodule

[rtl/ucal_date.sv]
// stages 3 to 7: year, month and day from the day number since 2000-01-01
module ucal_date import ucal_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] day_num,
  output logic [6:0]  year_offset,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  logic [4:0]  cyc3_r, cyc3_nxt, cyc4_r;
  logic [15:0] day3_r;
  logic [10:0] doc4_r, doc4_nxt;
  logic [6:0]  year5_r, year5_nxt, year6_r, year7_r;
  logic        leap5_r, leap5_nxt, leap6_r;
  doy_t        doy5_r, doy5_nxt, doy6_r;
  logic [3:0]  mi6_r, mi6_nxt;
  logic [3:0]  mon7_r, mon7_nxt;
  logic [4:0]  dom7_r, dom7_nxt;
  logic [32:0] cyc_prod;
  logic [15:0] cyc_back;
  logic [1:0]  yic;

  always_comb begin
    cyc_prod = 33'(day_num) * 33'(CYC_M);
    cyc3_nxt = cyc_prod[CYC_K+4:CYC_K];
  end

  always_comb begin
    cyc_back = 16'(cyc3_r) * 16'(DAYS_PER_CYCLE);
    doc4_nxt = 11'(day3_r - cyc_back);
  end

  // year within the four-year cycle
  always_comb begin
    if (doc4_r >= year_start(2'd3)) begin
      yic = 2'd3;
    end else if (doc4_r >= year_start(2'd2)) begin
      yic = 2'd2;
    end else if (doc4_r >= year_start(2'd1)) begin
      yic = 2'd1;
    end else begin
      yic = 2'd0;
    end
    year5_nxt = {cyc4_r, yic};
    leap5_nxt = (yic == 2'd0);
    doy5_nxt  = 9'(doc4_r - year_start(yic));
  end

  // month starts rise monotonically, so the last one passed wins
  always_comb begin
    mi6_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy5_r >= month_start(4'(k), leap5_r)) begin
        mi6_nxt = 4'(k);
      end
    end
  end

  always_comb begin
    mon7_nxt = mi6_r + 4'd1;
    dom7_nxt = 5'(doy6_r - month_start(mi6_r, leap6_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyc3_r  <= cyc3_nxt;
      day3_r  <= day_num;
      cyc4_r  <= cyc3_r;
      doc4_r  <= doc4_nxt;
      year5_r <= year5_nxt;
      leap5_r <= leap5_nxt;
      doy5_r  <= doy5_nxt;
      year6_r <= year5_r;
      leap6_r <= leap5_r;
      doy6_r  <= doy5_r;
      mi6_r   <= mi6_nxt;
      year7_r <= year6_r;
      mon7_r  <= mon7_nxt;
      dom7_r  <= dom7_nxt;
    end
  end

  assign year_offset = year7_r;
  assign month       = mon7_r;
  assign day         = dom7_r;

endmodule

[rtl/unix_seconds_to_calendar.sv]
// Converts a 32-bit Unix timestamp into the calendar date and time for the years 2000 to
// 2099 (no time zones, no leap seconds). It is a seven-stage pipeline: one transaction can
// enter every cycle unless a result waits untaken at the output, so the sustained rate is
// one timestamp per cycle. The whole pipeline advances together and
// holds while a finished result waits to be taken, which is the only thing that lowers
// in_ch.ready. The divisions by 86400, 1461, 3600 and 60 are reciprocal multiplications,
// each followed in the next stage by its multiply-back for the remainder. Timestamps
// outside 2000-01-01 00:00:00 to 2099-12-31 23:59:59 come out with out_of_range set and
// every other field zero.
module unix_seconds_to_calendar import ucal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ucal_in_if.sink     in_ch,
  ucal_out_if.source  out_ch
);

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] oor_r, oor_nxt;
  logic [31:0]       rest_r, rest_nxt;
  logic              en;
  logic [15:0]       day_num;
  logic [16:0]       sod;
  logic [6:0]        year_w;
  logic [3:0]        month_w;
  logic [4:0]        day_w;
  logic [4:0]        hour_w;
  logic [5:0]        minute_w;
  logic [5:0]        second_w;
  logic              oor_out;

  // everything moves unless the output holds a result nobody has taken
  assign en          = !vld_r[STAGES-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    vld_nxt  = {vld_r[STAGES-2:0], in_ch.valid};
    oor_nxt  = {oor_r[STAGES-2:0],
                (in_ch.unix_seconds < EPOCH_2000) || (in_ch.unix_seconds > LAST_2099)};
    rest_nxt = in_ch.unix_seconds - EPOCH_2000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r  <= oor_nxt;
      rest_r <= rest_nxt;
    end
  end

  ucal_daysplit u_daysplit (
    .clk     (clk),
    .en      (en),
    .rest    (rest_r),
    .day_num (day_num),
    .sod     (sod)
  );

  ucal_tod u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (sod),
    .hour   (hour_w),
    .minute (minute_w),
    .second (second_w)
  );

  ucal_date u_date (
    .clk         (clk),
    .en          (en),
    .day_num     (day_num),
    .year_offset (year_w),
    .month       (month_w),
    .day         (day_w)
  );

  assign oor_out = oor_r[STAGES-1];

  assign out_ch.valid        = vld_r[STAGES-1];
  assign out_ch.out_of_range = oor_out;
  assign out_ch.year_offset  = oor_out ? '0 : year_w;
  assign out_ch.month        = oor_out ? '0 : month_w;
  assign out_ch.day          = oor_out ? '0 : day_w;
  assign out_ch.hour         = oor_out ? '0 : hour_w;
  assign out_ch.minute       = oor_out ? '0 : minute_w;
  assign out_ch.second       = oor_out ? '0 : second_w;

endmodule

[rtl/ucal_checker.sv]
// port-level checks for the unix seconds to calendar converter, bound to the top level
module ucal_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] year_offset,
  input logic [3:0] month,
  input logic [4:0] day,
  input logic [4:0] hour,
  input logic [5:0] minute,
  input logic [5:0] second,
  input logic       out_of_range
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(year_offset) && $stable(month) &&
      $stable(day) && $stable(hour) && $stable(minute) && $stable(second) &&
      $stable(out_of_range))
    else $error("stalled result changed");

  // an empty output register never holds off the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled output freezes the whole pipeline
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> year_offset == 7'd0 && month == 4'd0 && day == 5'd0 &&
      hour == 5'd0 && minute == 6'd0 && second == 6'd0)
    else $error("out of range transaction with nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_of_range |-> year_offset <= 7'd99 && month >= 4'd1 &&
      month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 &&
      minute <= 6'd59 && second <= 6'd59)
    else $error("calendar field out of its range");

endmodule

bind unix_seconds_to_calendar ucal_checker u_ucal_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .year_offset  (out_ch.year_offset),
  .month        (out_ch.month),
  .day          (out_ch.day),
  .hour         (out_ch.hour),
  .minute       (out_ch.minute),
  .second       (out_ch.second),
  .out_of_range (out_ch.out_of_range)
);

[sim/tb_unix_seconds_to_calendar.sv]
// testbench for the unix seconds to calendar converter: directed table, then random timestamps
module tb_unix_seconds_to_calendar;
  timeunit 1ns;
  timeprecision 1ps;

  import ucal_pkg::*;

  localparam logic [31:0] DAY_SECS     = 32'd86400;
  localparam int          RANDOM_ITEMS = 1050;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          MAX_WAIT     = 17;

  typedef struct packed {
    logic [6:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       out_of_range;
  } calendar_t;

  typedef struct {
    logic [31:0] secs;
    bit          typed;
    calendar_t   want;
  } stim_row_t;

  localparam calendar_t CAL_OUT_OF_RANGE = '{out_of_range: 1'b1, default: '0};
  localparam calendar_t CAL_UNTYPED      = '0;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk;
  logic rst_n;

  ucal_in_if  in_ch();
  ucal_out_if out_ch();

  unix_seconds_to_calendar i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  calendar_t pending_dates [$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        burst_mode  = 1'b0;

  // calendar rows: extremes and error cases typed in, the rest predicted
  stim_row_t directed [25] = '{
    '{32'd0,                             1'b1, CAL_OUT_OF_RANGE},
    '{EPOCH_2000 - 32'd1,                1'b1, CAL_OUT_OF_RANGE},
    '{EPOCH_2000,                        1'b1, '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{EPOCH_2000 + 32'd59,               1'b1, '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd59, 1'b0}},
    '{EPOCH_2000 + 32'd86399,            1'b1, '{7'd0, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{EPOCH_2000 + DAY_SECS,             1'b1, '{7'd0, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 1'b0}},
    '{LAST_2099,                         1'b1, '{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{LAST_2099 + 32'd1,                 1'b1, CAL_OUT_OF_RANGE},
    '{32'hFFFF_FFFF,                     1'b1, CAL_OUT_OF_RANGE},
    '{EPOCH_2000 + 32'd31 * DAY_SECS,    1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd59 * DAY_SECS,    1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd60 * DAY_SECS - 32'd1, 1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd60 * DAY_SECS,    1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd366 * DAY_SECS - 32'd1, 1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd366 * DAY_SECS,   1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd425 * DAY_SECS,   1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd1520 * DAY_SECS,  1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd35123 * DAY_SECS, 1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd36160 * DAY_SECS, 1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd36160 * DAY_SECS - 32'd1, 1'b0, CAL_UNTYPED},
    '{EPOCH_2000 + 32'd12345678,         1'b0, CAL_UNTYPED},
    '{32'h7FFF_FFFF,                     1'b0, CAL_UNTYPED},
    '{32'h8000_0000,                     1'b0, CAL_UNTYPED},
    '{32'hAAAA_AAAA,                     1'b0, CAL_UNTYPED},
    '{32'h5555_5555,                     1'b0, CAL_UNTYPED}
  };

  function automatic calendar_t calendar_of(logic [31:0] secs);
    calendar_t   cal;
    int unsigned rest;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    bit          leap;
    cal = '0;
    if (secs < EPOCH_2000 || secs > LAST_2099) begin
      cal.out_of_range = 1'b1;
      return cal;
    end
    rest = secs - EPOCH_2000;
    cal.second = 6'(rest % 60);
    rest = rest / 60;
    cal.minute = 6'(rest % 60);
    rest = rest / 60;
    cal.hour = 5'(rest % 24);
    days = rest / 24;
    yr = 0;
    while (yr < 99) begin
      len = (yr % 4 == 0) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    leap = (yr % 4 == 0);
    mo = 0;
    while (mo < 11) begin
      len = MONTH_DAYS[mo] + ((leap && mo == 1) ? 1 : 0);
      if (days < len) break;
      days -= len;
      mo++;
    end
    cal.year_offset = 7'(yr);
    cal.month = 4'(mo + 1);
    cal.day = 5'(days + 1);
    return cal;
  endfunction

  // mix of uniform in-range stamps, stamps around month starts, edges and raw words
  function automatic logic [31:0] random_timestamp();
    int unsigned pick;
    int unsigned yr;
    int unsigned mo;
    int unsigned days;
    logic [31:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return EPOCH_2000 + $urandom_range(0, LAST_2099 - EPOCH_2000);
    end else if (pick < 70) begin
      yr = $urandom_range(0, 99);
      mo = $urandom_range(0, 11);
      days = yr * 365 + (yr + 3) / 4;
      for (int i = 0; i < mo; i++) begin
        days += MONTH_DAYS[i] + ((i == 1 && yr % 4 == 0) ? 1 : 0);
      end
      base = EPOCH_2000 + days * DAY_SECS;
      return ($urandom_range(0, 1) != 0) ? base - $urandom_range(1, 3) : base + $urandom_range(0, 3);
    end else if (pick < 80) begin
      base = ($urandom_range(0, 1) != 0) ? EPOCH_2000 : LAST_2099;
      return base + $urandom_range(0, 6) - 32'd3;
    end
    return $urandom();
  endfunction

  function automatic int unsigned draw_wait();
    return burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_timestamp(logic [31:0] secs, calendar_t want);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.unix_seconds <= secs;
    do @(posedge clk); while (!in_ch.ready);
    pending_dates.push_back(want);
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side: random stall before each transaction, none in burst stretches
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, actual %p", $time,
                 calendar_t'{out_ch.year_offset, out_ch.month, out_ch.day, out_ch.hour,
                             out_ch.minute, out_ch.second, out_ch.out_of_range});
      end else begin
        want = pending_dates.pop_front();
        check_field("year_offset", want.year_offset, out_ch.year_offset);
        check_field("month", want.month, out_ch.month);
        check_field("day", want.day, out_ch.day);
        check_field("hour", want.hour, out_ch.hour);
        check_field("minute", want.minute, out_ch.minute);
        check_field("second", want.second, out_ch.second);
        check_field("out_of_range", want.out_of_range, out_ch.out_of_range);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] secs;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.unix_seconds <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_timestamp(directed[i].secs,
                     directed[i].typed ? directed[i].want : calendar_of(directed[i].secs));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // switch between stretches with and without idling
      if (n % 64 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
      end
      secs = random_timestamp();
      send_timestamp(secs, calendar_of(secs));
    end
    in_ch.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (3 * STAGES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
